/* sv/jsu_pkg.sv */
// Shared types and codes for the JSON string unescape unit.
// Used by jsu_decode and json_string_unescape_unit; no dependencies.
package jsu_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_STR  = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	localparam logic [2:0] ST_DATA    = 3'd0;
	localparam logic [2:0] ST_DONE    = 3'd1;
	localparam logic [2:0] ST_EARLY   = 3'd2;
	localparam logic [2:0] ST_BADESC  = 3'd3;
	localparam logic [2:0] ST_BADHEX  = 3'd4;
	localparam logic [2:0] ST_NOQUOTE = 3'd5;

	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       last;
	} res_t;

	typedef struct packed {
		mode_t               mode;
		logic [1:0]          hex_cnt;
		logic [15:0]         cp;
		logic [1:0]          n;
		res_t [MAX_RES-1:0]  res;
	} dec_t;

endpackage

/* sv/json_string_unescape_unit.sv */
// Top level of the JSON string unescape unit: input register, parser state, result queue.
// Depends on jsu_pkg and jsu_decode.
//
// Takes one text byte per cycle and decodes one quoted JSON string token. Each input
// word gives zero to three result words; they enter a queue of QDEPTH words (at least
// three) and leave in order, one per cycle while the receiver is ready. An input word
// is held in the input register and decoded there combinationally, and its result words
// are then registered in the queue, from whose head they leave. The input side keeps
// taking a word every cycle as long as the queue has room for what the registered word
// produces; only a \u escape above 0x7F gives more than one result word (two or three),
// and the queue absorbs them. Status codes: 0 data, 1 complete, 2 ended early, 3 bad
// escape, 4 bad hex, 5 no opening quote.
module json_string_unescape_unit #(
	parameter int QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic [0:0] s_axis_tuser,   // [0] end_of_text
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [2:0] m_axis_tuser,   // [2:0] status
	output logic       m_axis_tlast
);

	localparam int CW = $clog2(QDEPTH + 1);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           eot_s1;
	jsu_pkg::mode_t mode_q;
	logic [1:0]     hex_cnt_q;
	logic [15:0]    cp_q;
	jsu_pkg::res_t  q_q [QDEPTH];
	logic [CW-1:0]  count_q;

	jsu_pkg::dec_t  dec;
	jsu_pkg::res_t  q_d [QDEPTH];
	logic [CW-1:0]  count_d;
	logic [CW-1:0]  cnt_after;
	logic           fire_s1;
	logic           pop;
	logic           take;

	jsu_decode u_dec (
		.in_byte (byte_s1),
		.eot     (eot_s1),
		.mode    (mode_q),
		.hex_cnt (hex_cnt_q),
		.cp      (cp_q),
		.dec     (dec)
	);

	assign fire_s1 = valid_s1 &&
		((CW + 1)'(count_q) + (CW + 1)'(dec.n) <= (CW + 1)'(QDEPTH));
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign take = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = (count_q != '0);
	assign pop = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = q_q[0].out_byte;
	assign m_axis_tuser = q_q[0].status;
	assign m_axis_tlast = q_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_axis_tdata;
			eot_s1 <= s_axis_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::MODE_IDLE;
			hex_cnt_q <= 2'd0;
			cp_q <= 16'd0;
		end else if (fire_s1) begin
			mode_q <= dec.mode;
			hex_cnt_q <= dec.hex_cnt;
			cp_q <= dec.cp;
		end
	end

	// shift out the head, then append new words behind the survivors
	always_comb begin
		int idx;
		cnt_after = count_q - CW'(pop);
		for (int i = 0; i < QDEPTH; i++) begin
			if (pop && i < QDEPTH - 1)
				q_d[i] = q_q[i + 1];
			else
				q_d[i] = q_q[i];
			idx = i - int'(cnt_after);
			if (fire_s1 && idx >= 0 && idx < int'(dec.n))
				q_d[i] = dec.res[idx[1:0]];
		end
		count_d = cnt_after + (fire_s1 ? CW'(dec.n) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++)
			q_q[i] <= q_d[i];
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("result queue overfilled");

	a_hex_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != jsu_pkg::MODE_HEX |-> (hex_cnt_q == 2'd0 && cp_q == 16'd0))
		else $error("hex gather state left over outside escape");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire_s1 |=> valid_s1 && $stable(byte_s1) && $stable(eot_s1))
		else $error("registered input word lost while stalled");
`endif

endmodule

/* sv/jsu_decode.sv */
// Decode step for one text byte: next parser state and up to three result words.
// Depends on jsu_pkg.
module jsu_decode (
	input  logic [7:0]     in_byte,
	input  logic           eot,
	input  jsu_pkg::mode_t mode,
	input  logic [1:0]     hex_cnt,
	input  logic [15:0]    cp,
	output jsu_pkg::dec_t  dec
);

	logic        is_ws;
	logic        hex_ok;
	logic [3:0]  digit;
	logic [15:0] cp_shift;
	logic        esc_ok;
	logic [7:0]  esc_byte;

	jsu_pkg::mode_t                        mode_d;
	logic [1:0]                            hex_cnt_d;
	logic [15:0]                           cp_d;
	logic [1:0]                            n_d;
	jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0]  res_d;

	assign is_ws = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
	assign cp_shift = {cp[11:0], digit};
	assign dec = '{mode: mode_d, hex_cnt: hex_cnt_d, cp: cp_d, n: n_d, res: res_d};

	always_comb begin
		hex_ok = 1'b1;
		digit = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			digit = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			digit = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			digit = 4'(in_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		esc_ok = 1'b1;
		esc_byte = in_byte;
		case (in_byte)
			8'h22, 8'h5C, 8'h2F: esc_byte = in_byte;
			8'h62: esc_byte = 8'h08;
			8'h66: esc_byte = 8'h0C;
			8'h6E: esc_byte = 8'h0A;
			8'h72: esc_byte = 8'h0D;
			8'h74: esc_byte = 8'h09;
			default: esc_ok = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		mode_d = mode;
		hex_cnt_d = hex_cnt;
		cp_d = cp;
		if (eot) begin
			mode_d = jsu_pkg::MODE_IDLE;
			hex_cnt_d = 2'd0;
			cp_d = 16'd0;
		end else begin
			case (mode)
				jsu_pkg::MODE_IDLE: begin
					if (in_byte == 8'h22)
						mode_d = jsu_pkg::MODE_STR;
				end
				jsu_pkg::MODE_STR: begin
					if (in_byte == 8'h22)
						mode_d = jsu_pkg::MODE_IDLE;
					else if (in_byte == 8'h5C)
						mode_d = jsu_pkg::MODE_ESC;
				end
				jsu_pkg::MODE_ESC: begin
					if (in_byte == 8'h75) begin
						mode_d = jsu_pkg::MODE_HEX;
						hex_cnt_d = 2'd0;
						cp_d = 16'd0;
					end else if (esc_ok) begin
						mode_d = jsu_pkg::MODE_STR;
					end else begin
						mode_d = jsu_pkg::MODE_IDLE;
					end
				end
				jsu_pkg::MODE_HEX: begin
					if (!hex_ok) begin
						mode_d = jsu_pkg::MODE_IDLE;
						hex_cnt_d = 2'd0;
						cp_d = 16'd0;
					end else if (hex_cnt == 2'd3) begin
						mode_d = jsu_pkg::MODE_STR;
						hex_cnt_d = 2'd0;
						cp_d = 16'd0;
					end else begin
						hex_cnt_d = hex_cnt + 2'd1;
						cp_d = cp_shift;
					end
				end
				default: mode_d = jsu_pkg::MODE_IDLE;
			endcase
		end
	end

	// result words
	always_comb begin
		n_d = 2'd0;
		res_d = '0;
		if (eot) begin
			n_d = 2'd1;
			res_d[0].status = jsu_pkg::ST_EARLY;
		end else begin
			case (mode)
				jsu_pkg::MODE_IDLE: begin
					if (!is_ws && in_byte != 8'h22) begin
						n_d = 2'd1;
						res_d[0].status = jsu_pkg::ST_NOQUOTE;
					end
				end
				jsu_pkg::MODE_STR: begin
					if (in_byte == 8'h22) begin
						n_d = 2'd1;
						res_d[0].status = jsu_pkg::ST_DONE;
					end else if (in_byte != 8'h5C) begin
						n_d = 2'd1;
						res_d[0].out_byte = in_byte;
						res_d[0].status = jsu_pkg::ST_DATA;
					end
				end
				jsu_pkg::MODE_ESC: begin
					if (in_byte == 8'h75) begin
						n_d = 2'd0;
					end else if (esc_ok) begin
						n_d = 2'd1;
						res_d[0].out_byte = esc_byte;
						res_d[0].status = jsu_pkg::ST_DATA;
					end else begin
						n_d = 2'd1;
						res_d[0].status = jsu_pkg::ST_BADESC;
					end
				end
				jsu_pkg::MODE_HEX: begin
					if (!hex_ok) begin
						n_d = 2'd1;
						res_d[0].status = jsu_pkg::ST_BADHEX;
					end else if (hex_cnt == 2'd3) begin
						if (cp_shift <= 16'h007F) begin
							n_d = 2'd1;
							res_d[0].out_byte = cp_shift[7:0];
						end else if (cp_shift <= 16'h07FF) begin
							n_d = 2'd2;
							res_d[0].out_byte = 8'hC0 | {3'd0, cp_shift[10:6]};
							res_d[1].out_byte = 8'h80 | {2'd0, cp_shift[5:0]};
						end else begin
							n_d = 2'd3;
							res_d[0].out_byte = 8'hE0 | {4'd0, cp_shift[15:12]};
							res_d[1].out_byte = 8'h80 | {2'd0, cp_shift[11:6]};
							res_d[2].out_byte = 8'h80 | {2'd0, cp_shift[5:0]};
						end
					end
				end
				default: n_d = 2'd0;
			endcase
		end
		if (n_d == 2'd1)
			res_d[0].last = 1'b1;
		else if (n_d == 2'd2)
			res_d[1].last = 1'b1;
		else if (n_d == 2'd3)
			res_d[2].last = 1'b1;
	end

endmodule
